@@ rtl/btk_pkg.sv @@
// shared constants and types of the bounded top-k set
package btk_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int KEY_BITS    = 32;
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

   localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(MAX_ENTRIES);
   localparam logic [CNT_BITS-1:0] CAP_MAX   = CNT_BITS'(MAX_ENTRIES);
   localparam logic [CNT_BITS-1:0] CAP_MIN   = CNT_BITS'(1);

   // update command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;   // grow: insert key in sorted place, shift larger keys up
      logic rep;   // replace: drop lowest cell, shift smaller keys down
   } ctl_type;

endpackage

@@ rtl/btk_cell.sv @@
// one cell of the sorted key chain: holds a key, compares it, shifts to neighbors
module btk_cell (
   input  logic                         clock,
   input  btk_pkg::ctl_type             ctl,
   input  logic [btk_pkg::KEY_BITS-1:0] key,
   input  logic                         valid,
   input  logic                         lt_lo,
   input  logic [btk_pkg::KEY_BITS-1:0] val_lo,
   input  logic                         lt_hi,
   input  logic [btk_pkg::KEY_BITS-1:0] val_hi,
   output logic                         lt,
   output logic                         eq,
   output logic [btk_pkg::KEY_BITS-1:0] val,
   output logic [btk_pkg::KEY_BITS-1:0] nxt
);

   logic [btk_pkg::KEY_BITS-1:0] val_ff;
   logic [btk_pkg::KEY_BITS-1:0] val_in;

   assign val = val_ff;
   assign lt  = valid && (val_ff < key);
   assign eq  = valid && (val_ff == key);

   always_comb begin
      val_in = val_ff;
      if (ctl.ins) begin
         // keys below the new one stay, the slot just above takes it
         if (!lt) begin
            val_in = lt_lo ? key : val_lo;
         end
      end else if (ctl.rep) begin
         // lowest key drops out, everything below the new key moves down
         if (lt_hi) begin
            val_in = val_hi;
         end else if (lt) begin
            val_in = key;
         end
      end
   end

   assign nxt = val_in;

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ rtl/bounded_top_k_set.sv @@
// top level of the bounded top-k set: cell chain, count, capacity and result register
//
// Keeps up to capacity distinct unsigned 32-bit keys, the largest seen so far, in a
// chain of 64 cells sorted ascending, so the lowest cell always holds the minimum.
// Every cell compares its key against the incoming key in the same cycle; the
// compare results give the duplicate flag and the insertion point, and the chain
// then shifts by one place toward the free end (grow) or toward the minimum
// (replace) on the clock edge. A new item is accepted as soon as the result
// register is empty or is being drained, so the block runs at one beat per cycle
// when the result side keeps up. Capacity 0 acts as 1 and values above 64 act as
// 64; lowering capacity below the held count leaves the count as it is and the
// set keeps replacing.
// Capacity may only be written while no beat is in flight.
module bounded_top_k_set (
   input  logic                                clock,
   input  logic                                reset,
   // candidate key channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [btk_pkg::KEY_BITS-1:0]        req_key,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_inserted,
   output logic                                rsp_evicted,
   output logic [btk_pkg::KEY_BITS-1:0]        rsp_evicted_key,
   output logic [btk_pkg::KEY_BITS-1:0]        rsp_worst_key,
   output logic [btk_pkg::CNT_BITS-1:0]        rsp_entry_count,
   // capacity register
   input  logic                                csr_we,
   input  logic [btk_pkg::CNT_BITS-1:0]        csr_wdata
);

   localparam int N = btk_pkg::MAX_ENTRIES;
   localparam int KB = btk_pkg::KEY_BITS;
   localparam int CB = btk_pkg::CNT_BITS;

   // capacity register and its clamped value
   logic [CB-1:0] cap_ff;
   logic [CB-1:0] cap_in;
   logic [CB-1:0] cap_eff;

   // held key count
   logic [CB-1:0] cnt_ff;
   logic [CB-1:0] cnt_in;

   // result register
   logic          rsp_valid_ff,   rsp_valid_in;
   logic          inserted_ff,    inserted_in;
   logic          evicted_ff,     evicted_in;
   logic [KB-1:0] ev_key_ff,      ev_key_in;
   logic [KB-1:0] worst_ff,       worst_in;
   logic [CB-1:0] count_ff,       count_in;

   // chain wiring, one extra slot at the top end for the boundary neighbor
   logic [N:0]    lt_w;
   logic [N-1:0]  eq_w;
   logic [KB-1:0] val_w [N+1];
   logic [KB-1:0] nxt_w [N];
   logic          lt_base;

   logic             accept;
   logic             dup;
   logic             full;
   btk_pkg::ctl_type ctl;

   // ---------------------------------------------------------------------------
   // capacity register
   // ---------------------------------------------------------------------------
   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = btk_pkg::CAP_MIN;
      end else if (cap_ff > btk_pkg::CAP_MAX) begin
         cap_eff = btk_pkg::CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // handshake: the result register parts the two channels
   // ---------------------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------------
   // cell chain, lowest key in cell 0
   // ---------------------------------------------------------------------------
   assign lt_base  = 1'b1;     // cell 0 has nothing below it to keep
   assign lt_w[N]  = 1'b0;     // nothing above the top cell moves down
   assign val_w[N] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic cell_valid;
      logic lt_lo_s;
      logic [KB-1:0] val_lo_s;

      assign cell_valid = cnt_ff > CB'(i);

      if (i == 0) begin : g_first
         assign lt_lo_s  = lt_base;
         assign val_lo_s = req_key;
      end else begin : g_rest
         assign lt_lo_s  = lt_w[i-1];
         assign val_lo_s = val_w[i-1];
      end

      btk_cell u_cell (
         .clock  (clock),
         .ctl    (ctl),
         .key    (req_key),
         .valid  (cell_valid),
         .lt_lo  (lt_lo_s),
         .val_lo (val_lo_s),
         .lt_hi  (lt_w[i+1]),
         .val_hi (val_w[i+1]),
         .lt     (lt_w[i]),
         .eq     (eq_w[i]),
         .val    (val_w[i]),
         .nxt    (nxt_w[i])
      );
   end

   // ---------------------------------------------------------------------------
   // update decision
   // ---------------------------------------------------------------------------
   assign dup  = |eq_w;
   assign full = cnt_ff >= cap_eff;

   always_comb begin
      ctl.ins = accept && !full && !dup;
      // cell 0 holds the minimum; a full set is never empty
      ctl.rep = accept && full && lt_w[0] && !dup;
   end

   assign cnt_in = ctl.ins ? cnt_ff + CB'(1) : cnt_ff;

   // ---------------------------------------------------------------------------
   // result beat
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      inserted_in  = inserted_ff;
      evicted_in   = evicted_ff;
      ev_key_in    = ev_key_ff;
      worst_in     = worst_ff;
      count_in     = count_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         inserted_in  = ctl.ins || ctl.rep;
         evicted_in   = ctl.rep;
         ev_key_in    = ctl.rep ? val_w[0] : '0;
         worst_in     = (cnt_in == '0) ? '0 : nxt_w[0];
         count_in     = cnt_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= btk_pkg::CAP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inserted_ff <= inserted_in;
      evicted_ff  <= evicted_in;
      ev_key_ff   <= ev_key_in;
      worst_ff    <= worst_in;
      count_ff    <= count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inserted    = inserted_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = ev_key_ff;
   assign rsp_worst_key   = worst_ff;
   assign rsp_entry_count = count_ff;

endmodule

@@ rtl/btk_checker.sv @@
// port-level checks of the bounded top-k set and their bind
module btk_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_inserted,
   input logic                         rsp_evicted,
   input logic [btk_pkg::KEY_BITS-1:0] rsp_evicted_key,
   input logic [btk_pkg::KEY_BITS-1:0] rsp_worst_key,
   input logic [btk_pkg::CNT_BITS-1:0] rsp_entry_count
);

   // a stalled result beat stays valid with its minimum and count unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_worst_key)
         && $stable(rsp_entry_count))
      else $error("result beat changed while stalled");

   // an eviction always comes with an insertion
   a_ev_ins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_inserted)
      else $error("eviction without insertion");

   // no eviction means an empty evicted key
   a_ev_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key set without eviction");

   // the new minimum lies above the evicted one
   a_ev_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_worst_key > rsp_evicted_key)
      else $error("minimum not above evicted key");

   // an empty set reports a zero minimum and no insertion
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_worst_key == '0 && !rsp_inserted)
      else $error("empty set with nonzero minimum");

endmodule

bind bounded_top_k_set btk_checker u_btk_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_inserted    (rsp_inserted),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key),
   .rsp_worst_key   (rsp_worst_key),
   .rsp_entry_count (rsp_entry_count)
);
